// ===== hdl/ews_pkg.sv =====
// Shared types, constants and Q16.16 arithmetic helpers for the elastic stencil engine.
`default_nettype none
package ews_pkg;

    localparam int ROW_LEN_W = 13;
    localparam int COEF_W    = 31;
    localparam int DAMP_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int FIFO_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TDX     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TDZ     = 2'd3;

    localparam logic MODE_STRESS   = 1'b0;
    localparam logic MODE_VELOCITY = 1'b1;

    localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 13'd512;

    typedef logic signed [31:0] t_q;

    // One non-halo cell with its gathered neighbors.
    typedef struct packed {
        logic               mode;
        t_q                 vx;
        t_q                 vz;
        t_q                 sxx;
        t_q                 szz;
        t_q                 sxz;
        logic [COEF_W-1:0]  lam;
        logic [COEF_W-1:0]  l2m;
        logic [COEF_W-1:0]  mu;
        logic [COEF_W-1:0]  ir;
        logic [DAMP_W-1:0]  damp;
        t_q                 nb1;   // left (velocity) or right (stress) neighbor
        t_q                 nb2;
        t_q                 ln1;   // row above (velocity) or row below (stress)
        t_q                 ln2;
    } t_job;

    function automatic t_q sat33(input logic signed [32:0] v);
        if (v > 33'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -33'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_q qadd(input t_q a, input t_q b);
        return sat33(33'(a) + 33'(b));
    endfunction

    function automatic t_q qsub(input t_q a, input t_q b);
        return sat33(33'(a) - 33'(b));
    endfunction

    // Product with fraction dropped toward minus infinity, saturated.
    function automatic t_q qmul(input logic signed [32:0] a, input logic signed [32:0] b);
        logic signed [65:0] p;
        logic signed [49:0] s;
        p = a * b;
        s = 50'(p >>> 16);
        if (s > 50'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (s < -50'sd2147483648) begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ews_cell_if.sv =====
// Valid/ready channel interfaces for input cells and result cells.
`default_nettype none
interface ews_in_if;
    logic               valid;
    logic               ready;
    logic               frame_start;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_z;
    logic signed [31:0] stress_xx;
    logic signed [31:0] stress_zz;
    logic signed [31:0] stress_xz;
    logic [30:0]        lame_lambda;
    logic [30:0]        lambda_plus_two_mu;
    logic [30:0]        shear_modulus;
    logic [30:0]        inverse_density;
    logic [16:0]        damping;

    modport source (output valid, frame_start, vel_x, vel_z, stress_xx, stress_zz,
                    stress_xz, lame_lambda, lambda_plus_two_mu, shear_modulus,
                    inverse_density, damping, input ready);
    modport sink   (input valid, frame_start, vel_x, vel_z, stress_xx, stress_zz,
                    stress_xz, lame_lambda, lambda_plus_two_mu, shear_modulus,
                    inverse_density, damping, output ready);
endinterface

interface ews_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_z_out;
    logic signed [31:0] stress_xx_out;
    logic signed [31:0] stress_zz_out;
    logic signed [31:0] stress_xz_out;

    modport source (output valid, vel_x_out, vel_z_out, stress_xx_out, stress_zz_out,
                    stress_xz_out, input ready);
    modport sink   (input valid, vel_x_out, vel_z_out, stress_xx_out, stress_zz_out,
                    stress_xz_out, output ready);
endinterface
`default_nettype wire

// ===== hdl/elastic_wave_stencil_update.sv =====
// Top level of the staggered-grid elastic stencil engine.
// Usage:
//  - i_cell carries one grid cell per beat (valid/ready). Velocity mode streams
//    cells in raster order, stress mode in reverse raster order. frame_start
//    marks the first cell of a grid pass and restarts the row/column tracking.
//  - The first streamed row and first column of every row are halo: they load
//    the line store and neighbor registers but produce no beat on o_cell.
//  - o_cell carries one result beat per non-halo cell, in input order.
//  - Configuration (mode, row length, dt/dx, dt/dz) is written on the plain
//    write port while the engine is idle.
// Timing:
//  - The front end takes a cell every cycle while its queue has room; the
//    line store read is registered in the front stage before the job is queued.
//  - The back end runs every job through a single shared 33x33 multiplier,
//    from queue pop through the run steps to the result beat, and pops the
//    next job only after that beat is taken; halo cells never reach the queue.
//  - A stalled receiver holds the result beat; the two-entry queue and the
//    front stage keep absorbing cells until full, then ready drops.
//  - Reset clears control state, neighbor registers and the position.
`default_nettype none
module elastic_wave_stencil_update
    import ews_pkg::*;
#(
    parameter int MAX_ROW_CELLS = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    ews_in_if.sink                     i_cell,
    ews_out_if.source                  o_cell,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [30:0]           i_cfg_data
);
    logic                 r_mode;
    logic [ROW_LEN_W-1:0] r_row_len;
    logic [COEF_W-1:0]    r_tdx, r_tdz;

    logic full, empty, push, pop;
    t_job push_job, head_job;

    // Hold register values; a write lands at the edge it is presented.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_STRESS;
            r_row_len <= ROW_LEN_RESET;
            r_tdx     <= '0;
            r_tdz     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:    r_mode    <= i_cfg_data[0];
                CFG_ROW_LEN: r_row_len <= i_cfg_data[ROW_LEN_W-1:0];
                CFG_TDX:     r_tdx     <= i_cfg_data;
                CFG_TDZ:     r_tdz     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ews_front #(.MAX_ROW_CELLS(MAX_ROW_CELLS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_in      (i_cell),
        .i_mode    (r_mode),
        .i_row_len (r_row_len),
        .i_full    (full),
        .o_push    (push),
        .o_job     (push_job)
    );

    ews_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (head_job)
    );

    ews_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .i_tdx   (r_tdx),
        .i_tdz   (r_tdz),
        .m_out   (o_cell)
    );
endmodule
`default_nettype wire

// ===== hdl/ews_front.sv =====
// Front end: accepts cells, tracks position, keeps line store and neighbor registers.
`default_nettype none
module ews_front
    import ews_pkg::*;
#(
    parameter int MAX_ROW_CELLS = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    ews_in_if.sink                     s_in,
    input  wire logic                  i_mode,
    input  wire logic [ROW_LEN_W-1:0]  i_row_len,
    input  wire logic                  i_full,
    output      logic                  o_push,
    output      t_job                  o_job
);
    localparam int CW = $clog2(MAX_ROW_CELLS);
    localparam int LW = CW + 1;

    logic [31:0]   mem1 [MAX_ROW_CELLS];
    logic [31:0]   mem2 [MAX_ROW_CELLS];
    logic [31:0]   r_rd1, r_rd2;
    logic [CW-1:0] r_col;
    logic          r_halo;
    t_q            r_prev1, r_prev2;
    logic          r_stg_vld;
    t_job          r_stg;

    logic [LW-1:0] len;
    logic [CW-1:0] col;
    logic [LW-1:0] col_nxt;
    logic          halo;
    logic          acc;
    logic          produce;

    always_comb begin
        if (i_row_len < ROW_LEN_W'(2)) begin
            len = LW'(2);
        end else if (32'(i_row_len) > 32'(MAX_ROW_CELLS)) begin
            len = LW'(MAX_ROW_CELLS);
        end else begin
            len = LW'(i_row_len);
        end
        halo = s_in.frame_start | r_halo;
        col  = s_in.frame_start ? '0 : r_col;
        if (LW'(col) >= len) begin
            col = '0;
        end
        col_nxt = LW'(col) + LW'(1);
    end

    assign s_in.ready = !r_stg_vld || !i_full;
    assign acc        = s_in.valid && s_in.ready;
    assign produce    = !halo && (col != '0);
    assign o_push     = r_stg_vld && !i_full;

    always_comb begin
        o_job     = r_stg;
        o_job.ln1 = r_rd1;
        o_job.ln2 = r_rd2;
    end

    // Read old entry and write new one at the same column.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd1 <= mem1[col];
            r_rd2 <= mem2[col];
            mem1[col] <= (i_mode == MODE_VELOCITY) ? s_in.stress_zz : s_in.vel_x;
            mem2[col] <= (i_mode == MODE_VELOCITY) ? s_in.stress_xz : s_in.vel_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_halo    <= 1'b1;
            r_prev1   <= '0;
            r_prev2   <= '0;
            r_stg_vld <= 1'b0;
        end else begin
            if (acc) begin
                if (col_nxt >= len) begin
                    r_col  <= '0;
                    r_halo <= 1'b0;
                end else begin
                    r_col  <= col_nxt[CW-1:0];
                    r_halo <= halo;
                end
                r_prev1   <= (i_mode == MODE_VELOCITY) ? s_in.stress_xx : s_in.vel_x;
                r_prev2   <= (i_mode == MODE_VELOCITY) ? s_in.stress_xz : s_in.vel_z;
                r_stg_vld <= produce;
            end else if (o_push) begin
                r_stg_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_stg.mode <= i_mode;
            r_stg.vx   <= s_in.vel_x;
            r_stg.vz   <= s_in.vel_z;
            r_stg.sxx  <= s_in.stress_xx;
            r_stg.szz  <= s_in.stress_zz;
            r_stg.sxz  <= s_in.stress_xz;
            r_stg.lam  <= s_in.lame_lambda;
            r_stg.l2m  <= s_in.lambda_plus_two_mu;
            r_stg.mu   <= s_in.shear_modulus;
            r_stg.ir   <= s_in.inverse_density;
            r_stg.damp <= s_in.damping;
            r_stg.nb1  <= r_prev1;
            r_stg.nb2  <= r_prev2;
            r_stg.ln1  <= '0;
            r_stg.ln2  <= '0;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ews_fifo.sv =====
// Short job queue between the front end and the arithmetic back end.
`default_nettype none
module ews_fifo
    import ews_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output      logic o_full,
    output      logic o_empty,
    output      t_job o_job
);
    localparam int PW = $clog2(FIFO_DEPTH);

    t_job                  r_mem [FIFO_DEPTH];
    logic [PW-1:0]         r_wp, r_rp;
    logic [$clog2(FIFO_DEPTH+1)-1:0] r_cnt;

    assign o_full  = (r_cnt == ($bits(r_cnt))'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + ($bits(r_cnt))'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - ($bits(r_cnt))'(1);
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ews_back.sv =====
// Back end: sequences the stencil arithmetic through one shared multiplier.
`default_nettype none
module ews_back
    import ews_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_empty,
    input  t_job                    i_job,
    output      logic               o_pop,
    input  wire logic [COEF_W-1:0]  i_tdx,
    input  wire logic [COEF_W-1:0]  i_tdz,
    ews_out_if.source               m_out
);
    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} t_state;

    localparam logic [3:0] VEL_LAST = 4'd8;
    localparam logic [3:0] STR_LAST = 4'd14;

    t_state r_state;
    logic [3:0] r_step;
    t_job r_job;
    t_q r_d0, r_d1, r_d2, r_d3;
    t_q r_p, r_a, r_b, r_c;
    logic signed [32:0] op_a, op_b;
    logic signed [32:0] tdx, tdz, damp, lam, l2m, mu, ir;

    assign tdx  = {2'b00, i_tdx};
    assign tdz  = {2'b00, i_tdz};
    assign damp = {16'd0, r_job.damp};
    assign lam  = {2'b00, r_job.lam};
    assign l2m  = {2'b00, r_job.l2m};
    assign mu   = {2'b00, r_job.mu};
    assign ir   = {2'b00, r_job.ir};

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    always_comb begin
        op_a = '0;
        op_b = '0;
        if (r_job.mode == MODE_VELOCITY) begin
            case (r_step)
                4'd0: begin op_a = tdx;      op_b = 33'(r_d0); end
                4'd1: begin op_a = tdz;      op_b = 33'(r_d1); end
                4'd2: begin op_a = tdx;      op_b = 33'(r_d2); end
                4'd3: begin op_a = tdz;      op_b = 33'(r_d3); end
                4'd4: begin op_a = ir;       op_b = 33'(r_a);  end
                4'd5: begin op_a = ir;       op_b = 33'(r_b);  end
                4'd6: begin op_a = 33'(r_a); op_b = damp;      end
                4'd7: begin op_a = 33'(r_b); op_b = damp;      end
                default: begin op_a = '0;    op_b = '0;        end
            endcase
        end else begin
            case (r_step)
                4'd0:  begin op_a = l2m;      op_b = tdx;       end
                4'd1:  begin op_a = 33'(r_p); op_b = 33'(r_d0); end
                4'd2:  begin op_a = lam;      op_b = tdz;       end
                4'd3:  begin op_a = 33'(r_p); op_b = 33'(r_d3); end
                4'd4:  begin op_a = lam;      op_b = tdx;       end
                4'd5:  begin op_a = 33'(r_p); op_b = 33'(r_d0); end
                4'd6:  begin op_a = l2m;      op_b = tdz;       end
                4'd7:  begin op_a = 33'(r_p); op_b = 33'(r_d3); end
                4'd8:  begin op_a = tdz;      op_b = 33'(r_d1); end
                4'd9:  begin op_a = tdx;      op_b = 33'(r_d2); end
                4'd10: begin op_a = 33'(r_a); op_b = damp;      end
                4'd11: begin op_a = mu;       op_b = 33'(r_c);  end
                4'd12: begin op_a = 33'(r_b); op_b = damp;      end
                4'd13: begin op_a = 33'(r_c); op_b = damp;      end
                default: begin op_a = '0;     op_b = '0;        end
            endcase
        end
    end

    always_comb begin
        m_out.valid         = (r_state == ST_OUT);
        m_out.vel_x_out     = (r_job.mode == MODE_VELOCITY) ? r_a : r_job.vx;
        m_out.vel_z_out     = (r_job.mode == MODE_VELOCITY) ? r_b : r_job.vz;
        m_out.stress_xx_out = (r_job.mode == MODE_VELOCITY) ? r_job.sxx : r_a;
        m_out.stress_zz_out = (r_job.mode == MODE_VELOCITY) ? r_job.szz : r_b;
        m_out.stress_xz_out = (r_job.mode == MODE_VELOCITY) ? r_job.sxz : r_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= ST_RUN;
                        r_step  <= '0;
                    end
                end
                ST_RUN: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == ((r_job.mode == MODE_VELOCITY) ? VEL_LAST : STR_LAST)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_out.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath: the registered product feeds the accumulate step of the next cycle.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            if (i_job.mode == MODE_VELOCITY) begin
                r_d0 <= qsub(i_job.sxx, i_job.nb1);
                r_d1 <= qsub(i_job.sxz, i_job.ln2);
                r_d2 <= qsub(i_job.sxz, i_job.nb2);
                r_d3 <= qsub(i_job.szz, i_job.ln1);
            end else begin
                r_d0 <= qsub(i_job.nb1, i_job.vx);
                r_d1 <= qsub(i_job.ln1, i_job.vx);
                r_d2 <= qsub(i_job.nb2, i_job.vz);
                r_d3 <= qsub(i_job.ln2, i_job.vz);
            end
        end
        if (r_state == ST_RUN) begin
            r_p <= qmul(op_a, op_b);
            if (r_job.mode == MODE_VELOCITY) begin
                case (r_step)
                    4'd1: r_a <= r_p;
                    4'd2: r_a <= qadd(r_a, r_p);
                    4'd3: r_b <= r_p;
                    4'd4: r_b <= qadd(r_b, r_p);
                    4'd5: r_a <= qadd(r_job.vx, r_p);
                    4'd6: r_b <= qadd(r_job.vz, r_p);
                    4'd7: r_a <= r_p;
                    4'd8: r_b <= r_p;
                    default: ;
                endcase
            end else begin
                case (r_step)
                    4'd2:  r_a <= qadd(r_job.sxx, r_p);
                    4'd4:  r_a <= qadd(r_a, r_p);
                    4'd6:  r_b <= qadd(r_job.szz, r_p);
                    4'd8:  r_b <= qadd(r_b, r_p);
                    4'd9:  r_c <= r_p;
                    4'd10: r_c <= qadd(r_c, r_p);
                    4'd11: r_a <= r_p;
                    4'd12: r_c <= qadd(r_job.sxz, r_p);
                    4'd13: r_b <= r_p;
                    4'd14: r_c <= r_p;
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the elastic wave stencil engine: directed and random cell streams.
`default_nettype none
module tb_top;
    import ews_pkg::*;

    localparam int ROW_CELLS  = 4096;
    localparam int SETTLE_CYC = 48;    // longest job plus queue and front stage
    localparam int STALL_LIM  = 6000;  // cycles without any beat before giving up

    typedef struct {
        bit          fs;
        t_q          vx, vz, sxx, szz, sxz;
        logic [30:0] lam, l2m, mu, ir;
        logic [16:0] damp;
    } cell_t;

    typedef struct {
        t_q vx, vz, sxx, szz, sxz;
    } field_set_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [30:0] i_cfg_data;

    ews_in_if  cell_in ();
    ews_out_if cell_out ();

    elastic_wave_stencil_update u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cell     (cell_in),
        .o_cell     (cell_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Mirror of the engine: configuration, neighbor registers and line stores.
    logic        cfg_mode;
    logic [12:0] cfg_row_len;
    logic [30:0] cfg_tdx, cfg_tdz;
    logic [31:0] line_first [ROW_CELLS];
    logic [31:0] line_second [ROW_CELLS];
    logic [31:0] prev_first, prev_second;
    int          col_pos;
    bit          halo_row;

    field_set_t  pending_updates[$];
    int          error_count;
    int          idle_cycles;
    bit          calm;   // suppress all random idling on both sides

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- Q16.16 arithmetic ----------------
    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clip32(p >>> 16);   // arithmetic shift drops the fraction toward minus infinity
    endfunction

    function automatic longint fx_add(input longint a, input longint b);
        return clip32(a + b);
    endfunction

    function automatic longint fx_sub(input longint a, input longint b);
        return clip32(a - b);
    endfunction

    // Advance the mirror by one cell; queue the update when the cell is not halo.
    task automatic predict_update(input cell_t c);
        longint vx, vz, sxx, szz, sxz, tdx, tdz, damp;
        longint n1, n2, a1, a2, d1, d2, d3, d4, gx, gz, nxx, nzz, nxz, shear;
        field_set_t r;
        int len;
        int col;
        vx = c.vx; vz = c.vz; sxx = c.sxx; szz = c.szz; sxz = c.sxz;
        tdx = cfg_tdx; tdz = cfg_tdz; damp = c.damp;
        len = cfg_row_len;
        if (len < 2) len = 2;
        if (len > ROW_CELLS) len = ROW_CELLS;
        if (c.fs) begin
            col_pos = 0;
            halo_row = 1'b1;
        end
        col = (col_pos >= len) ? 0 : col_pos;
        n1 = longint'($signed(prev_first));
        n2 = longint'($signed(prev_second));
        a1 = longint'($signed(line_first[col]));
        a2 = longint'($signed(line_second[col]));
        r.vx = c.vx; r.vz = c.vz; r.sxx = c.sxx; r.szz = c.szz; r.sxz = c.sxz;
        if (cfg_mode == MODE_VELOCITY) begin
            if (!halo_row && col != 0) begin
                d1 = fx_sub(sxx, n1);
                d2 = fx_sub(sxz, a2);
                d3 = fx_sub(sxz, n2);
                d4 = fx_sub(szz, a1);
                gx = fx_add(fx_mul(tdx, d1), fx_mul(tdz, d2));
                gz = fx_add(fx_mul(tdx, d3), fx_mul(tdz, d4));
                r.vx = t_q'(fx_mul(fx_add(vx, fx_mul(c.ir, gx)), damp));
                r.vz = t_q'(fx_mul(fx_add(vz, fx_mul(c.ir, gz)), damp));
                pending_updates.push_back(r);
            end
            line_first[col]  = c.szz;
            line_second[col] = c.sxz;
            prev_first  = c.sxx;
            prev_second = c.sxz;
        end else begin
            if (!halo_row && col != 0) begin
                d1 = fx_sub(n1, vx);   // dvx/dx
                d2 = fx_sub(a1, vx);   // dvx/dz
                d3 = fx_sub(n2, vz);   // dvz/dx
                d4 = fx_sub(a2, vz);   // dvz/dz
                nxx = fx_add(fx_add(sxx, fx_mul(fx_mul(c.l2m, tdx), d1)),
                             fx_mul(fx_mul(c.lam, tdz), d4));
                nzz = fx_add(fx_add(szz, fx_mul(fx_mul(c.lam, tdx), d1)),
                             fx_mul(fx_mul(c.l2m, tdz), d4));
                shear = fx_add(fx_mul(tdz, d2), fx_mul(tdx, d3));
                nxz = fx_add(sxz, fx_mul(c.mu, shear));
                r.sxx = t_q'(fx_mul(nxx, damp));
                r.szz = t_q'(fx_mul(nzz, damp));
                r.sxz = t_q'(fx_mul(nxz, damp));
                pending_updates.push_back(r);
            end
            line_first[col]  = c.vx;
            line_second[col] = c.vz;
            prev_first  = c.vx;
            prev_second = c.vz;
        end
        col++;
        if (col >= len) begin
            col = 0;
            halo_row = 1'b0;
        end
        col_pos = col;
    endtask

    // ---------------- value pickers ----------------
    function automatic t_q pick_q();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3: return $urandom;
            default: return t_q'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    function automatic logic [30:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 31'h7FFFFFFF;
            1: return '0;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 32'h0002_0000));
        endcase
    endfunction

    function automatic logic [16:0] pick_damp();
        case ($urandom_range(0, 9))
            0: return 17'h1FFFF;
            1: return '0;
            2: return 17'h10000;
            3: return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic cell_t rand_cell(input bit fs);
        cell_t c;
        c.fs = fs;
        c.vx = pick_q(); c.vz = pick_q();
        c.sxx = pick_q(); c.szz = pick_q(); c.sxz = pick_q();
        c.lam = pick_coef(); c.l2m = pick_coef(); c.mu = pick_coef(); c.ir = pick_coef();
        c.damp = pick_damp();
        return c;
    endfunction

    // ---------------- drive and check ----------------
    // Send one beat; valid stays high into the next call unless a gap is taken.
    task automatic send_cell(input cell_t c);
        int gap;
        if (!calm && $urandom_range(0, 99) < 18) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                cell_in.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        cell_in.valid              <= 1'b1;
        cell_in.frame_start        <= c.fs;
        cell_in.vel_x              <= c.vx;
        cell_in.vel_z              <= c.vz;
        cell_in.stress_xx          <= c.sxx;
        cell_in.stress_zz          <= c.szz;
        cell_in.stress_xz          <= c.sxz;
        cell_in.lame_lambda        <= c.lam;
        cell_in.lambda_plus_two_mu <= c.l2m;
        cell_in.shear_modulus      <= c.mu;
        cell_in.inverse_density    <= c.ir;
        cell_in.damping            <= c.damp;
        do @(posedge i_clk); while (!cell_in.ready);
        predict_update(c);
    endtask

    // Drop valid and wait until every update is out and the engine has gone quiet.
    task automatic drain();
        @(negedge i_clk);
        cell_in.valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_MODE:    cfg_mode    = val[0];
            CFG_ROW_LEN: cfg_row_len = val[12:0];
            CFG_TDX:     cfg_tdx     = val;
            CFG_TDZ:     cfg_tdz     = val;
            default: ;
        endcase
    endtask

    task automatic setup(input logic m, input logic [12:0] len, input logic [30:0] tdx,
                         input logic [30:0] tdz);
        write_reg(CFG_MODE, 31'(m));
        write_reg(CFG_ROW_LEN, 31'(len));
        write_reg(CFG_TDX, tdx);
        write_reg(CFG_TDZ, tdz);
    endtask

    // Stream one grid pass of random cells; frame_start on the first.
    task automatic send_pass(input int len, input int rows);
        for (int i = 0; i < len * rows; i++) send_cell(rand_cell(i == 0));
    endtask

    task automatic report_mismatch(input string what, input t_q got, input t_q want);
        error_count++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    // Receiver: random back-pressure.
    always @(negedge i_clk) begin
        cell_out.ready <= calm || ($urandom_range(0, 99) >= 18);
    end

    // Compare each update beat with the oldest prediction.
    always @(posedge i_clk) begin
        field_set_t want;
        if (i_rst_n && cell_out.valid && cell_out.ready) begin
            if (pending_updates.size() == 0) begin
                report_mismatch("unexpected beat vel_x", cell_out.vel_x_out, '0);
            end else begin
                want = pending_updates.pop_front();
                if (cell_out.vel_x_out !== want.vx)
                    report_mismatch("vel_x", cell_out.vel_x_out, want.vx);
                if (cell_out.vel_z_out !== want.vz)
                    report_mismatch("vel_z", cell_out.vel_z_out, want.vz);
                if (cell_out.stress_xx_out !== want.sxx)
                    report_mismatch("stress_xx", cell_out.stress_xx_out, want.sxx);
                if (cell_out.stress_zz_out !== want.szz)
                    report_mismatch("stress_zz", cell_out.stress_zz_out, want.szz);
                if (cell_out.stress_xz_out !== want.sxz)
                    report_mismatch("stress_xz", cell_out.stress_xz_out, want.sxz);
            end
        end
    end

    // Watchdog: count cycles with no beat on either side.
    always @(posedge i_clk) begin
        if ((cell_in.valid && cell_in.ready) || (cell_out.valid && cell_out.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIM) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------
    // Reset values: stress mode, 512-cell rows, zero time steps.
    task automatic test_reset_defaults();
        send_pass(512, 1);
        for (int i = 0; i < 8; i++) send_cell(rand_cell(1'b0));
        drain();
    endtask

    task automatic test_velocity_extremes();
        cell_t c;
        setup(MODE_VELOCITY, 13'd0, 31'h7FFFFFFF, 31'h7FFFFFFF);   // length below 2 acts as 2
        for (int i = 0; i < 8; i++) begin
            c = rand_cell(i == 0);
            if (i[0]) begin
                c.sxx = 32'sh80000000; c.szz = 32'sh7FFFFFFF; c.sxz = 32'sh80000000;
                c.ir = 31'h7FFFFFFF; c.damp = 17'h1FFFF;
            end else begin
                c.sxx = 32'sh7FFFFFFF; c.szz = 32'sh80000000; c.sxz = 32'sh7FFFFFFF;
                c.ir = '0; c.damp = '0;
            end
            send_cell(c);
        end
        drain();
    endtask

    task automatic test_stress_extremes();
        cell_t c;
        setup(MODE_STRESS, 13'd3, 31'h7FFFFFFF, 31'd0);
        for (int i = 0; i < 9; i++) begin
            c = rand_cell(i == 0);
            c.vx = i[0] ? 32'sh80000000 : 32'sh7FFFFFFF;
            c.vz = i[1] ? 32'sh7FFFFFFF : 32'sh80000000;
            c.lam = 31'h7FFFFFFF; c.l2m = 31'h7FFFFFFF; c.mu = 31'h7FFFFFFF;
            c.damp = (i == 8) ? 17'h1FFFF : 17'h10000;
            send_cell(c);
        end
        drain();
    endtask

    // frame_start in mid-row restarts the position and the halo row.
    task automatic test_frame_restart();
        setup(MODE_VELOCITY, 13'd4, 31'h0001_0000, 31'h0000_8000);
        send_pass(4, 2);
        send_cell(rand_cell(1'b0));
        send_cell(rand_cell(1'b0));
        send_pass(4, 3);
        drain();
    endtask

    // Lengths above the store depth act as the store depth: the halo row does not wrap early.
    task automatic test_row_clamp();
        setup(MODE_STRESS, 13'h1FFF, 31'h0000_4000, 31'h0000_2000);
        send_pass(24, 1);
        drain();
    endtask

    // Change registers mid-pass after draining; the stores keep their contents.
    task automatic test_midpass_change();
        setup(MODE_VELOCITY, 13'd5, 31'h0000_C000, 31'h0001_4000);
        send_pass(5, 2);
        drain();
        write_reg(CFG_TDX, 31'h0002_0000);
        write_reg(CFG_MODE, 31'(MODE_STRESS));
        for (int i = 0; i < 10; i++) send_cell(rand_cell(1'b0));
        drain();
        write_reg(CFG_ROW_LEN, 31'd3);   // shrinking only
        for (int i = 0; i < 9; i++) send_cell(rand_cell(1'b0));
        drain();
    endtask

    task automatic test_random_passes();
        int sent;
        int len;
        int rows;
        int pass_no;
        sent = 0;
        pass_no = 0;
        while (sent < 700) begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
            rows = $urandom_range(2, 6);
            setup(1'($urandom_range(0, 1)), 13'(len),
                  ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h30000)),
                  ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h30000)));
            calm = (pass_no % 7 == 3);   // a long stretch with no idling
            send_pass(len, rows);
            sent += len * rows;
            // Sender waits for every update once, then a short broken pass.
            if (pass_no == 5) begin
                drain();
                send_pass(len, 1);
                send_cell(rand_cell(1'b1));
                sent += len + 1;
            end
            drain();
            calm = 1'b0;
            pass_no++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MODE;
        i_cfg_data = '0;
        cell_in.valid = 1'b0;
        cell_in.frame_start = 1'b0;
        cell_in.vel_x = '0;
        cell_in.vel_z = '0;
        cell_in.stress_xx = '0;
        cell_in.stress_zz = '0;
        cell_in.stress_xz = '0;
        cell_in.lame_lambda = '0;
        cell_in.lambda_plus_two_mu = '0;
        cell_in.shear_modulus = '0;
        cell_in.inverse_density = '0;
        cell_in.damping = '0;
        cell_out.ready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        calm = 1'b0;
        cfg_mode = MODE_STRESS;
        cfg_row_len = ROW_LEN_RESET;
        cfg_tdx = '0;
        cfg_tdz = '0;
        prev_first = '0;
        prev_second = '0;
        col_pos = 0;
        halo_row = 1'b1;
        for (int i = 0; i < ROW_CELLS; i++) begin
            line_first[i] = '0;
            line_second[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_velocity_extremes();
        test_stress_extremes();
        test_frame_restart();
        test_row_clamp();
        test_midpass_change();
        test_random_passes();

        drain();
        if (error_count == 0 && pending_updates.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
